/* rtl/core/srcd_pkg.sv */
// Shared types, constants and the CRC-8 step for the sensor response deframer.
package srcd_pkg;

	// Frame layout
	localparam int BYTES_PER_WORD = 2;
	localparam int WORD_W         = 16;
	localparam int WITHIN_W       = $clog2(BYTES_PER_WORD + 1);
	localparam int WIDX_W         = 2;
	localparam int MEAS_WORDS     = 3;

	// CRC-8 parameters: poly 0x31, init 0xFF, MSB first
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	// Status word readiness mask
	localparam logic [WORD_W-1:0] READY_MASK = 16'h07FF;

	// Fixed-point conversion constants
	localparam int TEMP_SCALE  = 17500;
	localparam int TEMP_OFFSET = 4500;
	localparam int RH_SCALE    = 10000;
	localparam int TPROD_W     = 31;
	localparam int RPROD_W     = 30;
	localparam int TEMP_W      = 15;
	localparam int RH_W        = 14;

	typedef enum logic [1:0] {
		ST_MEAS_OK   = 2'd0,
		ST_READY     = 2'd1,
		ST_NOT_READY = 2'd2,
		ST_CRC_ERR   = 2'd3
	} status_t;

	// Completed frame handed from parser to converter
	typedef struct packed {
		status_t           status;
		logic [WORD_W-1:0] co2_raw;
		logic [WORD_W-1:0] t_raw;
		logic [WORD_W-1:0] rh_raw;
	} frame_t;

	// One byte through the CRC-8 register
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* rtl/core/srcd_parser.sv */
// Byte parser: input register, frame state, CRC check and completed-frame register.
module srcd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	input  logic                frame_start,
	input  logic                frame_kind,
	output logic                frm_valid,
	output srcd_pkg::frame_t    frm,
	input  logic                frm_ready
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       kind_s1;

	// Frame state
	logic [srcd_pkg::WITHIN_W-1:0] within_q;
	logic [srcd_pkg::WIDX_W-1:0]   widx_q;
	logic [7:0]                    crc_q;
	logic                          kind_q;
	logic                          fail_q;
	logic                          active_q;
	logic [srcd_pkg::WORD_W-1:0]   word_q [srcd_pkg::MEAS_WORDS];

	// Completed frame register
	logic             frm_valid_s2;
	srcd_pkg::frame_t frm_s2;

	logic ready_s1, ready_s2, fire_s1;

	logic                          kind_eff, fail_eff, active_eff;
	logic [srcd_pkg::WITHIN_W-1:0] within_eff;
	logic [srcd_pkg::WIDX_W-1:0]   widx_eff, last_widx;
	logic [7:0]                    crc_eff;
	logic                          is_crc, is_last, fail_nx;
	logic [srcd_pkg::WORD_W-1:0]   cur_word;
	srcd_pkg::frame_t              frm_nx;

	assign ready_s2 = !frm_valid_s2 || frm_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign fire_s1  = valid_s1 && ready_s2;
	assign in_stall = !ready_s1;

	// Frame start restarts the parser state for this word
	always_comb begin
		kind_eff   = start_s1 ? kind_s1 : kind_q;
		within_eff = start_s1 ? '0 : within_q;
		widx_eff   = start_s1 ? '0 : widx_q;
		crc_eff    = start_s1 ? srcd_pkg::CRC_INIT : crc_q;
		fail_eff   = start_s1 ? 1'b0 : fail_q;
		active_eff = start_s1 || active_q;
		is_crc     = within_eff == srcd_pkg::WITHIN_W'(srcd_pkg::BYTES_PER_WORD);
		last_widx  = kind_eff ? srcd_pkg::WIDX_W'(srcd_pkg::MEAS_WORDS - 1) : '0;
		is_last    = active_eff && is_crc && (widx_eff == last_widx);
		fail_nx    = fail_eff || (is_crc && (crc_eff != byte_s1));
	end

	// Word being assembled
	always_comb begin
		cur_word = word_q[0];
		for (int i = 1; i < srcd_pkg::MEAS_WORDS; i++) begin
			if (widx_eff == srcd_pkg::WIDX_W'(i)) begin
				cur_word = word_q[i];
			end
		end
	end

	// Result of a finished frame
	always_comb begin
		frm_nx.co2_raw = word_q[0];
		frm_nx.t_raw   = word_q[1];
		frm_nx.rh_raw  = word_q[2];
		if (fail_nx) begin
			frm_nx.status = srcd_pkg::ST_CRC_ERR;
		end else if (!kind_eff) begin
			frm_nx.status = ((word_q[0] & srcd_pkg::READY_MASK) != '0) ?
				srcd_pkg::ST_READY : srcd_pkg::ST_NOT_READY;
		end else begin
			frm_nx.status = srcd_pkg::ST_MEAS_OK;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
			kind_s1  <= frame_kind;
		end
	end

	// Frame control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			within_q <= '0;
			widx_q   <= '0;
			crc_q    <= srcd_pkg::CRC_INIT;
			kind_q   <= 1'b0;
			fail_q   <= 1'b0;
			active_q <= 1'b0;
		end else if (fire_s1 && active_eff) begin
			kind_q   <= kind_eff;
			fail_q   <= fail_nx;
			active_q <= !is_last;
			if (is_crc) begin
				within_q <= '0;
				widx_q   <= widx_eff + 1'b1;
				crc_q    <= srcd_pkg::CRC_INIT;
			end else begin
				within_q <= within_eff + 1'b1;
				widx_q   <= widx_eff;
				crc_q    <= srcd_pkg::crc8_byte(crc_eff, byte_s1);
			end
		end
	end

	// Word store, big-endian shift-in of data bytes
	always_ff @(posedge clk) begin
		for (int i = 0; i < srcd_pkg::MEAS_WORDS; i++) begin
			if (fire_s1 && active_eff && !is_crc && (widx_eff == srcd_pkg::WIDX_W'(i))) begin
				word_q[i] <= {cur_word[srcd_pkg::WORD_W-9:0], byte_s1};
			end
		end
	end

	// Completed frame register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frm_valid_s2 <= 1'b0;
		end else if (fire_s1 && is_last) begin
			frm_valid_s2 <= 1'b1;
		end else if (frm_ready) begin
			frm_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && is_last) begin
			frm_s2 <= frm_nx;
		end
	end

	assign frm_valid = frm_valid_s2;
	assign frm       = frm_s2;

endmodule

/* rtl/core/srcd_convert.sv */
// Converter: scales raw temperature and humidity words into output units.
module srcd_convert (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         frm_valid,
	input  srcd_pkg::frame_t             frm,
	output logic                         frm_ready,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [15:0]                  co2_ppm,
	output logic signed [srcd_pkg::TEMP_W-1:0] temp_centi_c,
	output logic [srcd_pkg::RH_W-1:0]    rh_centi_pct
);

	// Product stage
	logic                           valid_s3;
	srcd_pkg::status_t              status_s3;
	logic [srcd_pkg::WORD_W-1:0]    co2_s3;
	logic [srcd_pkg::TPROD_W-1:0]   tprod_s3;
	logic [srcd_pkg::RPROD_W-1:0]   rprod_s3;

	// Result register
	logic                           out_valid_q;
	srcd_pkg::status_t              status_q;
	logic [srcd_pkg::WORD_W-1:0]    co2_q;
	logic [srcd_pkg::TEMP_W-1:0]    temp_q;
	logic [srcd_pkg::RH_W-1:0]      rh_q;

	logic ready_out, ready_s3;

	logic [srcd_pkg::TPROD_W:0]   tsum;
	logic [srcd_pkg::RPROD_W:0]   rsum;
	logic [srcd_pkg::TEMP_W-1:0]  tq;
	logic [srcd_pkg::RH_W-1:0]    rq;

	assign ready_out = !out_valid_q || !out_stall;
	assign ready_s3  = !valid_s3 || ready_out;
	assign frm_ready = ready_s3;

	// floor(x/65535) = (x + (x >> 16) + 1) >> 16 for quotients below 2^16
	always_comb begin
		tsum = (srcd_pkg::TPROD_W+1)'(tprod_s3) + (srcd_pkg::TPROD_W+1)'(tprod_s3 >> 16)
			+ (srcd_pkg::TPROD_W+1)'(1);
		rsum = (srcd_pkg::RPROD_W+1)'(rprod_s3) + (srcd_pkg::RPROD_W+1)'(rprod_s3 >> 16)
			+ (srcd_pkg::RPROD_W+1)'(1);
		tq   = tsum[16 +: srcd_pkg::TEMP_W];
		rq   = rsum[16 +: srcd_pkg::RH_W];
	end

	// Multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= frm_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && frm_valid) begin
			status_s3 <= frm.status;
			co2_s3    <= frm.co2_raw;
			tprod_s3  <= srcd_pkg::TPROD_W'(frm.t_raw) * srcd_pkg::TPROD_W'(srcd_pkg::TEMP_SCALE);
			rprod_s3  <= srcd_pkg::RPROD_W'(frm.rh_raw) * srcd_pkg::RPROD_W'(srcd_pkg::RH_SCALE);
		end
	end

	// Result register; data fields are zero unless the measurement is good
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_s3) begin
			status_q <= status_s3;
			if (status_s3 == srcd_pkg::ST_MEAS_OK) begin
				co2_q  <= co2_s3;
				temp_q <= tq - srcd_pkg::TEMP_W'(srcd_pkg::TEMP_OFFSET);
				rh_q   <= rq;
			end else begin
				co2_q  <= '0;
				temp_q <= '0;
				rh_q   <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign co2_ppm      = co2_q;
	assign temp_centi_c = temp_q;
	assign rh_centi_pct = rh_q;

endmodule

/* rtl/core/sensor_response_crc_deframer.sv */
// Top level of the CRC-checked sensor response deframer.
//
//  channel | words                                         | handshake
//  --------+-----------------------------------------------+------------------
//  in      | rx_byte, frame_start, frame_kind              | in_valid/in_stall
//  out     | status, co2_ppm, temp_centi_c, rh_centi_pct   | out_valid/out_stall
//
// One input byte is taken every cycle while in_stall is low; a frame's result is offered once
// its last byte has passed the input, frame, multiply and result registers in that order.
// Reset clears all control state; the word store holds no reset value.
// A stalled output backs up stage by stage and raises in_stall only once every
// stage holds a word.
module sensor_response_crc_deframer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                rx_byte,
	input  logic                      frame_start,
	input  logic                      frame_kind,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic [15:0]               co2_ppm,
	output logic signed [14:0]        temp_centi_c,
	output logic [13:0]               rh_centi_pct
);

	logic             frm_valid;
	logic             frm_ready;
	srcd_pkg::frame_t frm;

	srcd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.frame_kind  (frame_kind),
		.frm_valid   (frm_valid),
		.frm         (frm),
		.frm_ready   (frm_ready)
	);

	srcd_convert u_convert (
		.clk          (clk),
		.arst_n       (arst_n),
		.frm_valid    (frm_valid),
		.frm          (frm),
		.frm_ready    (frm_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.co2_ppm      (co2_ppm),
		.temp_centi_c (temp_centi_c),
		.rh_centi_pct (rh_centi_pct)
	);

endmodule
